// ===== src/ssdp_pkg.sv =====
package ssdp_pkg;

  // Parser phases
  localparam logic [4:0] PH_MAGIC     = 5'd0;
  localparam logic [4:0] PH_VERSION   = 5'd1;
  localparam logic [4:0] PH_TYPE      = 5'd2;
  localparam logic [4:0] PH_TYPE_X    = 5'd3;
  localparam logic [4:0] PH_EXP_SEC   = 5'd4;
  localparam logic [4:0] PH_EXP_MS    = 5'd5;
  localparam logic [4:0] PH_DB        = 5'd6;
  localparam logic [4:0] PH_CKSUM     = 5'd7;
  localparam logic [4:0] PH_DONE      = 5'd8;
  localparam logic [4:0] PH_STR_BYTES = 5'd9;
  localparam logic [4:0] PH_INT       = 5'd10;
  localparam logic [4:0] PH_LZF_BYTES = 5'd11;
  localparam logic [4:0] PH_LEN       = 5'd12;
  localparam logic [4:0] PH_LEN_LAST  = 5'd23;

  // Length prefix purposes
  localparam logic [1:0] LP_STR  = 2'd0;
  localparam logic [1:0] LP_CNT  = 2'd1;
  localparam logic [1:0] LP_CLEN = 2'd2;
  localparam logic [1:0] LP_RAW  = 2'd3;

  // Token kinds
  localparam logic [3:0] TK_VERSION    = 4'd0;
  localparam logic [3:0] TK_DB         = 4'd1;
  localparam logic [3:0] TK_RECORD     = 4'd2;
  localparam logic [3:0] TK_STR_START  = 4'd3;
  localparam logic [3:0] TK_STR_BYTE   = 4'd4;
  localparam logic [3:0] TK_INT_STR    = 4'd5;
  localparam logic [3:0] TK_COMP_START = 4'd6;
  localparam logic [3:0] TK_COUNT      = 4'd7;
  localparam logic [3:0] TK_END        = 4'd8;
  localparam logic [3:0] TK_CHECKSUM   = 4'd9;
  localparam logic [3:0] TK_ERROR      = 4'd10;

  // Opcodes
  localparam logic [7:0] OP_EXP_SEC = 8'hfd;
  localparam logic [7:0] OP_EXP_MS  = 8'hfc;
  localparam logic [7:0] OP_DB      = 8'hfe;
  localparam logic [7:0] OP_EOF     = 8'hff;

  localparam int unsigned MS_PER_SEC = 1000;
  localparam int unsigned DIV_STEPS  = 4;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [63:0] token_value;
    logic [31:0] int_value;
    logic [31:0] compressed_length;
    logic [7:0]  record_type;
    logic [31:0] expire_seconds;
    logic [1:0]  string_role;
    logic        is_compressed;
  } token_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  // Signature bytes of the dump header
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] m;
    unique case (idx)
      3'd0:    m = 8'h52;
      3'd1:    m = 8'h45;
      3'd2:    m = 8'h44;
      3'd3:    m = 8'h49;
      3'd4:    m = 8'h53;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [4:0] len_phase(input logic [1:0] purpose, input logic [1:0] sub);
    logic [4:0] p;
    p = PH_LEN + ({3'd0, purpose} * 5'd3) + {3'd0, sub};
    return p;
  endfunction

endpackage

// ===== src/ssdp_byte_if.sv =====
interface ssdp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ===== src/ssdp_token_if.sv =====
interface ssdp_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [63:0] token_value;
  logic signed [31:0] int_value;
  logic [31:0] compressed_length;
  logic [7:0]  record_type;
  logic signed [31:0] expire_seconds;
  logic [1:0]  string_role;
  logic        is_compressed;

  modport source (output valid, output token_kind, output token_value, output int_value,
                  output compressed_length, output record_type, output expire_seconds,
                  output string_role, output is_compressed, input ready);
  modport sink (input valid, input token_kind, input token_value, input int_value,
                input compressed_length, input record_type, input expire_seconds,
                input string_role, input is_compressed, output ready);
endinterface

// ===== src/ssdp_div1000.sv =====
module ssdp_div1000
  import ssdp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam logic [25:0] DIVISOR = 26'(MS_PER_SEC);
  // ceil(2^36 / 1000), exact for any partial dividend below 2^26
  localparam logic [26:0] RECIP   = 27'd68719477;

  logic [2:0]  cnt_q, cnt_d;
  logic [63:0] dq_q, dq_d;
  logic [9:0]  rem_q, rem_d;
  logic        done_q, done_d;
  logic [25:0] part;
  logic [52:0] prod;
  logic [15:0] qdig;
  logic [25:0] back;

  // One 16-bit quotient digit per cycle by reciprocal multiply
  always_comb begin
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    part   = {rem_q, dq_q[63:48]};
    prod   = {27'd0, part} * {26'd0, RECIP};
    qdig   = prod[51:36];
    back   = part - ({10'd0, qdig} * DIVISOR);
    if (req_i.start) begin
      cnt_d = 3'(DIV_STEPS);
      dq_d  = req_i.dividend;
      rem_d = '0;
    end else if (cnt_q != 3'd0) begin
      rem_d  = back[9:0];
      dq_d   = {dq_q[47:0], qdig};
      cnt_d  = cnt_q - 3'd1;
      done_d = (cnt_q == 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = (cnt_q != 3'd0) || done_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = dq_q[31:0];

`ifndef NO_ASSERTIONS
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.start && rsp_o.busy)) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(cnt_q == 3'd1)) else $error("divider done out of step");
  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> (cnt_q == 3'(DIV_STEPS))) else $error("divider did not load");
`endif

endmodule

// ===== src/ssdp_core.sv =====
module ssdp_core
  import ssdp_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  ssdp_byte_if.sink      in_if,
  ssdp_token_if.source   out_if,
  output div_req_t       div_req_o,
  input  div_rsp_t       div_rsp_i
);

  logic [4:0]  phase_q, phase_d;
  logic [3:0]  hc_q, hc_d;
  logic [13:0] ver_q, ver_d;
  logic [63:0] ash_q, ash_d;
  logic [31:0] sr_q, sr_d;
  logic [32:0] elem_q, elem_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] exp_q, exp_d;
  logic        pair_q, pair_d;
  logic        halt_q, halt_d;
  logic        ov_q, ov_d;
  token_t      tok_q, tok_d;

  logic        accept, emit, sd, ld, msdiv;
  logic [1:0]  ld_purp, purp, sub, role;
  logic [31:0] ld_len, sr_inc, sr_dec, ival;
  logic [63:0] ash_le;
  logic [4:0]  k;
  logic [17:0] vmul;
  logic [32:0] elem_n;
  logic        pair_n;
  logic [7:0]  b;
  logic [5:0]  low;

  assign accept   = in_if.valid && in_if.ready;
  assign b        = in_if.data_byte;
  assign low      = b[5:0];
  assign role     = hc_q[1:0];
  assign sr_inc   = sr_q + 32'd1;
  assign sr_dec   = sr_q - 32'd1;
  assign ash_le   = ash_q | ({56'd0, b} << {sr_q[2:0], 3'b000});
  assign vmul     = ({4'd0, ver_q} * 18'd10) + {14'd0, b[3:0]};
  assign k        = phase_q - PH_LEN;

  // Split a length phase into purpose and byte position
  always_comb begin
    if (k < 5'd3) begin
      purp = LP_STR;
      sub  = k[1:0];
    end else if (k < 5'd6) begin
      purp = LP_CNT;
      sub  = 2'(k - 5'd3);
    end else if (k < 5'd9) begin
      purp = LP_CLEN;
      sub  = 2'(k - 5'd6);
    end else begin
      purp = LP_RAW;
      sub  = 2'(k - 5'd9);
    end
  end

  // Sign extend the little-endian integer string
  always_comb begin
    unique case (hc_q[3:2])
      2'd0:    ival = {{24{ash_le[7]}}, ash_le[7:0]};
      2'd1:    ival = {{16{ash_le[15]}}, ash_le[15:0]};
      default: ival = ash_le[31:0];
    endcase
  end

  // Parse one beat
  always_comb begin
    phase_d = phase_q;
    hc_d    = hc_q;
    ver_d   = ver_q;
    ash_d   = ash_q;
    sr_d    = sr_q;
    elem_d  = elem_q;
    type_d  = type_q;
    exp_d   = exp_q;
    pair_d  = pair_q;
    halt_d  = halt_q;
    emit    = 1'b0;
    sd      = 1'b0;
    ld      = 1'b0;
    ld_purp = LP_STR;
    ld_len  = '0;
    msdiv   = 1'b0;
    elem_n  = elem_q;
    pair_n  = pair_q;
    tok_d   = '0;

    if (accept && !halt_q) begin
      unique case (phase_q)
        PH_MAGIC: begin
          if (b != magic_byte(hc_q[2:0])) begin
            halt_d           = 1'b1;
            emit             = 1'b1;
            tok_d.token_kind = TK_ERROR;
          end else if (hc_q + 4'd1 >= 4'd5) begin
            hc_d    = '0;
            ver_d   = '0;
            ash_d   = '0;
            phase_d = PH_VERSION;
          end else begin
            hc_d = hc_q + 4'd1;
          end
        end
        PH_VERSION: begin
          if (ash_q == 64'd0 && b >= 8'h30 && b <= 8'h39) ver_d = vmul[13:0];
          else ash_d = 64'd1;
          hc_d = hc_q + 4'd1;
          if (hc_q + 4'd1 >= 4'd4) begin
            hc_d              = '0;
            phase_d           = PH_TYPE;
            emit              = 1'b1;
            tok_d.token_kind  = TK_VERSION;
            tok_d.token_value = {50'd0, ver_d};
          end
        end
        PH_TYPE, PH_TYPE_X: begin
          if (phase_q == PH_TYPE) exp_d = 32'hffff_ffff;
          if (b == OP_EXP_SEC || b == OP_EXP_MS) begin
            sr_d    = '0;
            ash_d   = '0;
            phase_d = (b == OP_EXP_SEC) ? PH_EXP_SEC : PH_EXP_MS;
          end else if (b == OP_DB) begin
            phase_d = PH_DB;
          end else if (b == OP_EOF) begin
            sr_d             = '0;
            ash_d            = '0;
            phase_d          = (ver_q > 14'd5) ? PH_CKSUM : PH_DONE;
            emit             = 1'b1;
            tok_d.token_kind = TK_END;
          end else begin
            type_d            = b;
            hc_d              = '0;
            phase_d           = PH_LEN;
            emit              = 1'b1;
            tok_d.token_kind  = TK_RECORD;
            tok_d.token_value = {56'd0, b};
          end
        end
        PH_EXP_SEC: begin
          ash_d = ash_le;
          sr_d  = sr_inc;
          if (sr_inc >= 32'd4) begin
            exp_d   = ash_le[31:0];
            phase_d = PH_TYPE_X;
          end
        end
        PH_EXP_MS: begin
          ash_d = ash_le;
          sr_d  = sr_inc;
          if (sr_inc >= 32'd8) begin
            msdiv   = 1'b1;
            phase_d = PH_TYPE_X;
          end
        end
        PH_DB: begin
          phase_d           = PH_TYPE;
          emit              = 1'b1;
          tok_d.token_kind  = TK_DB;
          tok_d.token_value = {56'd0, b};
        end
        PH_CKSUM: begin
          ash_d = ash_le;
          sr_d  = sr_inc;
          if (sr_inc >= 32'd8) begin
            phase_d           = PH_DONE;
            emit              = 1'b1;
            tok_d.token_kind  = TK_CHECKSUM;
            tok_d.token_value = ash_le;
          end
        end
        PH_STR_BYTES, PH_LZF_BYTES: begin
          emit                = 1'b1;
          tok_d.token_kind    = TK_STR_BYTE;
          tok_d.token_value   = {56'd0, b};
          tok_d.string_role   = role;
          tok_d.is_compressed = (phase_q == PH_LZF_BYTES);
          sr_d                = sr_dec;
          sd                  = (sr_dec == 32'd0);
        end
        PH_INT: begin
          ash_d = ash_le;
          sr_d  = sr_inc;
          if (sr_inc >= (32'd1 << hc_q[3:2])) begin
            emit              = 1'b1;
            tok_d.token_kind  = TK_INT_STR;
            tok_d.int_value   = ival;
            tok_d.string_role = role;
            sd                = 1'b1;
          end
        end
        default: begin
          if (phase_q >= PH_LEN && phase_q <= PH_LEN_LAST) begin
            ld_purp = purp;
            unique case (sub)
              2'd0: begin
                unique case (b[7:6])
                  2'd0: begin
                    ld     = 1'b1;
                    ld_len = {26'd0, low};
                  end
                  2'd1: begin
                    ash_d   = {58'd0, low};
                    phase_d = len_phase(purp, 2'd1);
                  end
                  2'd2: begin
                    ash_d   = '0;
                    hc_d    = {2'd0, role};
                    phase_d = len_phase(purp, 2'd2);
                  end
                  default: begin
                    if (purp != LP_STR) begin
                      ld     = 1'b1;
                      ld_len = {26'd0, low};
                    end else if (low <= 6'd2) begin
                      hc_d    = {low[1:0], role};
                      sr_d    = '0;
                      ash_d   = '0;
                      phase_d = PH_INT;
                    end else if (low == 6'd3) begin
                      phase_d = len_phase(LP_CLEN, 2'd0);
                    end else begin
                      halt_d           = 1'b1;
                      emit             = 1'b1;
                      tok_d.token_kind = TK_ERROR;
                    end
                  end
                endcase
              end
              2'd1: begin
                ld     = 1'b1;
                ld_len = {18'd0, ash_q[5:0], b};
              end
              default: begin
                ash_d = {32'd0, ash_q[23:0], b};
                if (hc_q[3:2] == 2'd3) begin
                  hc_d   = {2'd0, role};
                  ld     = 1'b1;
                  ld_len = {ash_q[23:0], b};
                end else begin
                  hc_d = {hc_q[3:2] + 2'd1, role};
                end
              end
            endcase
          end
        end
      endcase

      // Finish a length prefix
      if (ld) begin
        unique case (ld_purp)
          LP_STR: begin
            sr_d              = ld_len;
            emit              = 1'b1;
            tok_d.token_kind  = TK_STR_START;
            tok_d.token_value = {32'd0, ld_len};
            tok_d.string_role = role;
            if (ld_len != 32'd0) phase_d = PH_STR_BYTES;
            else sd = 1'b1;
          end
          LP_CNT: begin
            elem_d            = {1'b0, ld_len};
            pair_d            = 1'b0;
            emit              = 1'b1;
            tok_d.token_kind  = TK_COUNT;
            tok_d.token_value = {32'd0, ld_len};
            if (ld_len == 32'd0) phase_d = PH_TYPE;
            else begin
              hc_d    = {2'd0, role};
              phase_d = PH_LEN;
            end
          end
          LP_CLEN: begin
            sr_d    = ld_len;
            phase_d = len_phase(LP_RAW, 2'd0);
          end
          default: begin
            emit                    = 1'b1;
            tok_d.token_kind        = TK_COMP_START;
            tok_d.token_value       = {32'd0, ld_len};
            tok_d.compressed_length = sr_q;
            tok_d.string_role       = role;
            tok_d.is_compressed     = 1'b1;
            if (sr_q != 32'd0) phase_d = PH_LZF_BYTES;
            else sd = 1'b1;
          end
        endcase
      end

      // Move on after a finished string
      if (sd) begin
        unique case (role)
          2'd0: begin
            if (type_q == 8'd0 || (type_q >= 8'd9 && type_q <= 8'd13)) begin
              hc_d    = 4'd1;
              phase_d = PH_LEN;
            end else if (type_q == 8'd1 || type_q == 8'd2) begin
              hc_d    = 4'd2;
              phase_d = len_phase(LP_CNT, 2'd0);
            end else if (type_q == 8'd3 || type_q == 8'd4) begin
              hc_d    = 4'd3;
              phase_d = len_phase(LP_CNT, 2'd0);
            end else begin
              phase_d = PH_TYPE;
            end
          end
          2'd1: phase_d = PH_TYPE;
          default: begin
            if (role == 2'd2) begin
              elem_n = elem_q - 33'd1;
            end else begin
              pair_n = ~pair_q;
              elem_n = pair_n ? elem_q : (elem_q - 33'd1);
            end
            elem_d = elem_n;
            pair_d = pair_n;
            if (elem_n == 33'd0) phase_d = PH_TYPE;
            else begin
              hc_d    = {2'd0, role};
              phase_d = PH_LEN;
            end
          end
        endcase
      end

      tok_d.record_type    = type_d;
      tok_d.expire_seconds = exp_d;
    end

    if (div_rsp_i.done) exp_d = div_rsp_i.quot;
  end

  // Output register: load on a token, clear when taken
  always_comb begin
    ov_d = ov_q && !out_if.ready;
    if (emit) ov_d = 1'b1;
  end

  assign in_if.ready = !div_rsp_i.busy && (!ov_q || out_if.ready);

  assign div_req_o.start    = msdiv;
  assign div_req_o.dividend = ash_le;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC;
      hc_q    <= '0;
      ver_q   <= '0;
      ash_q   <= '0;
      sr_q    <= '0;
      elem_q  <= '0;
      type_q  <= '0;
      exp_q   <= 32'hffff_ffff;
      pair_q  <= 1'b0;
      halt_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hc_q    <= hc_d;
      ver_q   <= ver_d;
      ash_q   <= ash_d;
      sr_q    <= sr_d;
      elem_q  <= elem_d;
      type_q  <= type_d;
      exp_q   <= exp_d;
      pair_q  <= pair_d;
      halt_q  <= halt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) tok_q <= tok_d;
  end

  assign out_if.valid             = ov_q;
  assign out_if.token_kind        = tok_q.token_kind;
  assign out_if.token_value       = tok_q.token_value;
  assign out_if.int_value         = tok_q.int_value;
  assign out_if.compressed_length = tok_q.compressed_length;
  assign out_if.record_type       = tok_q.record_type;
  assign out_if.expire_seconds    = tok_q.expire_seconds;
  assign out_if.string_role       = tok_q.string_role;
  assign out_if.is_compressed     = tok_q.is_compressed;

`ifndef NO_ASSERTIONS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt flag cleared");
  a_halted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (halt_q && !ov_q) |=> !ov_q) else $error("token after halt");
  a_div_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.busy |-> !in_if.ready) else $error("input taken during division");
  a_div_from_ms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msdiv |-> (phase_q == PH_EXP_MS)) else $error("division started outside expiry");
`endif

endmodule

// ===== src/snapshot_dump_record_parser_unit.sv =====
// Channel   Dir  Beat                         Handshake
// in_if     in   data_byte (8)                valid/ready
// out_if    out  token fields (kind..compr.)  valid/ready
//
// One byte per cycle when ready; each byte yields at most one token in the next cycle.
// A millisecond expiry ends with a 4-step divide by 1000 (16 quotient bits a
// step) that holds the input after the eighth expiry byte until it is done.
// Reset (rst_ni low, async) returns the parser to the signature phase.
// A stalled output holds its token; input keeps flowing while the output
// register is empty or being taken the same cycle, and no divide is running.
module snapshot_dump_record_parser_unit
  import ssdp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  ssdp_byte_if.sink    in_if,
  ssdp_token_if.source out_if
);

  div_req_t div_req;
  div_rsp_t div_rsp;

  ssdp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_if),
    .out_if    (out_if),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp)
  );

  ssdp_div1000 u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule
